// ===== rtl/pilp_pkg.sv =====
package pilp_pkg;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_BODY   = 2'd1,
    PH_ZERO   = 2'd2,
    PH_DIGITS = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    RAD_DEC = 2'd0,
    RAD_HEX = 2'd1,
    RAD_BIN = 2'd2
  } radix_e;

  localparam logic [7:0]  CH_PLUS   = 8'h2B;
  localparam logic [7:0]  CH_MINUS  = 8'h2D;
  localparam logic [7:0]  CH_ZERO   = 8'h30;
  localparam logic [7:0]  CH_ONE    = 8'h31;
  localparam logic [7:0]  CH_NINE   = 8'h39;
  localparam logic [7:0]  CH_X      = 8'h78;
  localparam logic [7:0]  CH_B      = 8'h62;
  localparam logic [7:0]  CH_LO_A   = 8'h61;
  localparam logic [7:0]  CH_LO_F   = 8'h66;
  localparam logic [7:0]  CH_UP_A   = 8'h41;
  localparam logic [7:0]  CH_UP_F   = 8'h46;
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  localparam logic signed [31:0] ERROR_VALUE = -32'sd2147483647;

  typedef struct packed {
    phase_e      phase;
    logic        negative;
    radix_e      radix;
    logic [31:0] accum;
    logic [15:0] used;
  } state_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic               is_error;
    logic [15:0]        chars_used;
  } result_t;

  function automatic logic [15:0] sat_inc(input logic [15:0] cnt);
    sat_inc = (cnt == COUNT_MAX) ? cnt : cnt + 16'd1;
  endfunction

  // bit 4 set when the character is a digit of the radix, bits 3:0 its value
  function automatic logic [4:0] digit_of(input logic [7:0] ch, input radix_e radix);
    logic [4:0] res;
    res = 5'd0;
    if (radix == RAD_BIN) begin
      if (ch == CH_ZERO || ch == CH_ONE) res = {1'b1, 3'd0, ch[0]};
    end else if (ch >= CH_ZERO && ch <= CH_NINE) begin
      res = {1'b1, ch[3:0]};
    end else if (radix == RAD_HEX) begin
      if ((ch >= CH_LO_A && ch <= CH_LO_F) || (ch >= CH_UP_A && ch <= CH_UP_F)) begin
        res = {1'b1, ch[3:0] + 4'd9};
      end
    end
    digit_of = res;
  endfunction

endpackage

// ===== rtl/pilp_step.sv =====
module pilp_step import pilp_pkg::*; (
  input  logic [7:0] ch_i,
  input  logic       start_req_i,
  input  state_t     state_i,
  output state_t     state_o,
  output logic       res_valid_o,
  output result_t    res_o
);

  always_comb begin
    state_t      s;
    logic [4:0]  dig;
    logic        digits_path;
    logic [31:0] scaled;
    s           = state_i;
    dig         = 5'd0;
    digits_path = 1'b0;
    scaled      = 32'd0;
    res_valid_o = 1'b0;
    res_o       = '0;

    if (start_req_i) begin
      s.phase    = PH_BODY;
      s.negative = 1'b0;
      s.radix    = RAD_DEC;
      s.accum    = 32'd0;
      s.used     = 16'd0;
    end

    if (start_req_i && (ch_i == CH_MINUS || ch_i == CH_PLUS)) begin
      s.negative = (ch_i == CH_MINUS);
      s.used     = 16'd1;
    end else begin
      unique case (s.phase)
        PH_IDLE: begin
        end
        PH_BODY: begin
          if (ch_i == CH_ZERO) begin
            s.accum = 32'd0;
            s.used  = sat_inc(s.used);
            s.phase = PH_ZERO;
          end else if (ch_i >= CH_ONE && ch_i <= CH_NINE) begin
            s.accum = {28'd0, ch_i[3:0]};
            s.radix = RAD_DEC;
            s.used  = sat_inc(s.used);
            s.phase = PH_DIGITS;
          end else begin
            res_valid_o      = 1'b1;
            res_o.value      = ERROR_VALUE;
            res_o.is_error   = 1'b1;
            res_o.chars_used = s.used;
            s.phase          = PH_IDLE;
          end
        end
        PH_ZERO: begin
          s.phase = PH_DIGITS;
          if (ch_i == CH_X) begin
            s.radix = RAD_HEX;
            s.used  = sat_inc(s.used);
          end else if (ch_i == CH_B) begin
            s.radix = RAD_BIN;
            s.used  = sat_inc(s.used);
          end else begin
            s.radix     = RAD_DEC;
            digits_path = 1'b1;
          end
        end
        PH_DIGITS: begin
          digits_path = 1'b1;
        end
      endcase

      if (digits_path) begin
        dig = digit_of(ch_i, s.radix);
        if (dig[4]) begin
          unique case (s.radix)
            RAD_HEX: scaled = {s.accum[27:0], 4'd0};
            RAD_BIN: scaled = {s.accum[30:0], 1'b0};
            default: scaled = {s.accum[28:0], 3'd0} + {s.accum[30:0], 1'b0};
          endcase
          s.accum = scaled + {28'd0, dig[3:0]};
          s.used  = sat_inc(s.used);
        end else begin
          res_valid_o      = 1'b1;
          res_o.value      = s.negative ? -s.accum : s.accum;
          res_o.is_error   = 1'b0;
          res_o.chars_used = s.used;
          s.phase          = PH_IDLE;
        end
      end
    end

    state_o = s;
  end

endmodule

// ===== rtl/prefixed_integer_literal_parser.sv =====
// channel  | handshake              | payload
// in       | in_valid_i, in_stall_o | ch_i, start_req_i
// out      | out_valid_o, out_stall_i | value_o, is_error_o, chars_used_o
//
// one character per cycle while not stalled; each result is registered
// the parse step is a single combinational pass from the parse state register
// rst_ni clears the parse state and both slot valid flags, no result pending
// a result slot plus a skid slot decouple the sides; in_stall_o rises only
// when the skid slot holds a result
module prefixed_integer_literal_parser import pilp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         ch_i,
  input  logic               start_req_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] value_o,
  output logic               is_error_o,
  output logic [15:0]        chars_used_o
);

  localparam state_t STATE_RESET = '{
    phase: PH_IDLE, negative: 1'b0, radix: RAD_DEC, accum: 32'd0, used: 16'd0
  };

  state_t  state_q, state_d, step_state;
  result_t step_res, out_q, out_d, skid_q, skid_d;
  logic    step_res_valid;
  logic    out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;
  logic    in_accept, out_take, res_new;

  pilp_step u_step (
    .ch_i        (ch_i),
    .start_req_i (start_req_i),
    .state_i     (state_q),
    .state_o     (step_state),
    .res_valid_o (step_res_valid),
    .res_o       (step_res)
  );

  assign in_stall_o = skid_valid_q;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_take   = out_valid_q && !out_stall_i;
  assign res_new    = in_accept && step_res_valid;
  assign state_d    = in_accept ? step_state : state_q;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    skid_valid_d = skid_valid_q;
    skid_d       = skid_q;
    if (!out_valid_q || out_take) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = res_new;
        if (res_new) out_d = step_res;
      end
    end else if (res_new) begin
      skid_valid_d = 1'b1;
      skid_d       = step_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= STATE_RESET;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o  = out_valid_q;
  assign value_o      = out_q.value;
  assign is_error_o   = out_q.is_error;
  assign chars_used_o = out_q.chars_used;

endmodule

// ===== rtl/pilp_checker.sv =====
module pilp_checker import pilp_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [31:0] value_o,
  input logic               is_error_o,
  input logic [15:0]        chars_used_o
);

  // a held-back result implies one already on the output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("stall without a pending result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(out_valid_o && out_stall_i && in_valid_i))
    else $error("stall raised without a blocked result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_error_o |-> value_o == ERROR_VALUE && chars_used_o <= 16'd1)
    else $error("error result malformed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(value_o)
      && $stable(is_error_o) && $stable(chars_used_o))
    else $error("stalled result changed");

endmodule

bind prefixed_integer_literal_parser pilp_checker u_pilp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .value_o      (value_o),
  .is_error_o   (is_error_o),
  .chars_used_o (chars_used_o)
);
